// ----- rtl/spc_pkg.sv -----
// shared types and constants for the spiral index to coordinate pipeline
package spc_pkg;

	localparam int unsigned SIDE_W = 16;
	localparam int unsigned POS_W  = 32;
	localparam int unsigned SQ_STAGES = 8;
	localparam int unsigned STEPS_PER_STAGE = 2;

	// payload while the square root is worked out
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  area;
		logic [SIDE_W-1:0] c;
		logic              side_bad;
		logic [POS_W-1:0]  rem;
		logic [POS_W-1:0]  root;
	} sq_t;

	// payload after the ring number and inner square are known
	typedef struct packed {
		logic              err;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  inner;
		logic [SIDE_W-1:0] k;
		logic [SIDE_W-1:0] c;
	} ring_t;

	// payload after the side and step split
	typedef struct packed {
		logic              err;
		logic              corner;
		logic [1:0]        side_sel;
		logic [SIDE_W:0]   step;
		logic [SIDE_W-1:0] k;
		logic [SIDE_W-1:0] c;
	} split_t;

endpackage

// ----- rtl/spc_sqrt_stage.sv -----
// two digit steps of the integer square root, registered
module spc_sqrt_stage #(
	parameter int unsigned STAGE = 0
) (
	input  logic          clk,
	input  logic          en,
	input  spc_pkg::sq_t  d,
	output spc_pkg::sq_t  q
);
	import spc_pkg::*;

	sq_t nxt;

	// restoring root digits, highest bit pair first
	always_comb begin
		logic [POS_W-1:0] bitv;
		logic [POS_W:0]   trial;
		nxt = d;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			bitv = POS_W'(1) << (POS_W - 2 - 2 * (STAGE * STEPS_PER_STAGE + i));
			trial = {1'b0, nxt.root} + {1'b0, bitv};
			if ({1'b0, nxt.rem} >= trial) begin
				nxt.rem  = nxt.rem - trial[POS_W-1:0];
				nxt.root = (nxt.root >> 1) + bitv;
			end else begin
				nxt.root = nxt.root >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- rtl/spc_ring_stage.sv -----
// ring number, inner square and error flag, registered
module spc_ring_stage (
	input  logic           clk,
	input  logic           en,
	input  spc_pkg::sq_t   d,
	output spc_pkg::ring_t q
);
	import spc_pkg::*;

	logic [SIDE_W:0]   r_inc;
	logic [SIDE_W-1:0] k;
	logic [SIDE_W-1:0] odd;

	// k = (r + 1) / 2, odd = 2k - 1
	assign r_inc = {1'b0, d.root[SIDE_W-1:0]} + (SIDE_W+1)'(1);
	assign k     = r_inc[SIDE_W:1];
	assign odd   = {k[SIDE_W-2:0], 1'b0} - SIDE_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			q.err   <= (d.pos == '0) || (d.pos > d.area) || d.side_bad;
			q.pos   <= d.pos;
			q.inner <= POS_W'(odd) * POS_W'(odd);
			q.k     <= k;
			q.c     <= d.c;
		end
	end
endmodule

// ----- rtl/spc_split_stage.sv -----
// offset past the inner square split into side and step, registered
module spc_split_stage (
	input  logic            clk,
	input  logic            en,
	input  spc_pkg::ring_t  d,
	output spc_pkg::split_t q
);
	import spc_pkg::*;

	// the offset stays below 8k, so three compares find the side
	logic [SIDE_W+2:0] m;
	logic [SIDE_W+2:0] d1;
	logic [SIDE_W+2:0] d2;
	logic [SIDE_W+2:0] d3;
	logic [1:0]        sel;
	logic [SIDE_W+2:0] base;

	assign m  = (SIDE_W+3)'(d.pos - d.inner);
	assign d1 = {2'b00, d.k, 1'b0};
	assign d2 = {1'b0, d.k, 2'b00};
	assign d3 = d1 + d2;

	always_comb begin
		if (m < d1) begin
			sel = 2'd0;
			base = '0;
		end else if (m < d2) begin
			sel = 2'd1;
			base = d1;
		end else if (m < d3) begin
			sel = 2'd2;
			base = d2;
		end else begin
			sel = 2'd3;
			base = d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.err      <= d.err;
			q.corner   <= (d.pos == d.inner);
			q.side_sel <= sel;
			q.step     <= (SIDE_W+1)'(m - base);
			q.k        <= d.k;
			q.c        <= d.c;
		end
	end
endmodule

// ----- rtl/spiral_index_to_coordinate_core.sv -----
// top level: spiral position to grid row and column, fully pipelined
//
// input channel s_*: tdata carries side_length in [15:0] and position in
// [47:16]; one query per transfer.
// output channel m_*: tdata carries row in [15:0] and column in [31:16],
// tuser carries index_error; one result per query, in query order.
// the pipeline has 12 register stages: one stage for the side square, eight
// stages of two root digits each for the square root of position, then
// ring, side split and coordinate stages, each registered in that order.
// throughput is one query per cycle while the receiver takes results;
// the root pipeline sets the depth.
// each stage holds a valid bit and loads when it or a later stage is free,
// so bubbles close up while the receiver stalls and nothing is dropped.
// an error (position zero, beyond side squared, or side above MAX_SIDE)
// gives row and column of zero with index_error set.
// reset clears all valid bits; data registers are not reset.
module spiral_index_to_coordinate_core #(
	parameter int unsigned MAX_SIDE = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // side_length, position
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // row, column
	output logic        m_tuser    // index_error
);
	import spc_pkg::*;

	localparam int unsigned NST = SQ_STAGES + 4;
	localparam int unsigned RING = SQ_STAGES + 1;
	localparam int unsigned SPLIT = SQ_STAGES + 2;
	localparam int unsigned OUT = SQ_STAGES + 3;

	logic [NST-1:0] v_q;
	logic [NST-1:0] rdy;
	sq_t            sq_s [SQ_STAGES+1];
	ring_t          ring_s;
	split_t         split_s;
	logic [15:0]    row_s;
	logic [15:0]    col_s;
	logic           err_s;
	logic [SIDE_W-1:0] side_in;

	assign side_in = s_tdata[15:0];

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		rdy[NST-1] = !v_q[NST-1] || m_tready;
		for (int i = NST - 2; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	assign s_tready = rdy[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// front stage: side square, grid center, root seed
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			sq_s[0].pos      <= s_tdata[47:16];
			sq_s[0].area     <= POS_W'(side_in) * POS_W'(side_in);
			sq_s[0].c        <= SIDE_W'(({1'b0, side_in} + 17'd1) >> 1);
			sq_s[0].side_bad <= side_in > SIDE_W'(MAX_SIDE);
			sq_s[0].rem      <= s_tdata[47:16];
			sq_s[0].root     <= '0;
		end
	end

	// square root pipeline
	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
		spc_sqrt_stage #(.STAGE(g)) u_sqrt (
			.clk (clk),
			.en  (rdy[g+1]),
			.d   (sq_s[g]),
			.q   (sq_s[g+1])
		);
	end

	spc_ring_stage u_ring (
		.clk (clk),
		.en  (rdy[RING]),
		.d   (sq_s[SQ_STAGES]),
		.q   (ring_s)
	);

	spc_split_stage u_split (
		.clk (clk),
		.en  (rdy[SPLIT]),
		.d   (ring_s),
		.q   (split_s)
	);

	// coordinate select into the output register
	always_ff @(posedge clk) begin
		logic [15:0] ck;
		logic [15:0] cmk;
		logic [15:0] b;
		if (rdy[OUT]) begin
			ck  = split_s.c + split_s.k;
			cmk = split_s.c - split_s.k;
			b   = split_s.step[15:0];
			err_s <= split_s.err;
			if (split_s.err) begin
				row_s <= '0;
				col_s <= '0;
			end else if (split_s.corner) begin
				row_s <= ck - 16'd1;
				col_s <= ck - 16'd1;
			end else begin
				case (split_s.side_sel)
					2'd0: begin
						row_s <= ck;
						col_s <= ck - b;
					end
					2'd1: begin
						row_s <= ck - b;
						col_s <= cmk;
					end
					2'd2: begin
						row_s <= cmk;
						col_s <= cmk + b;
					end
					default: begin
						row_s <= cmk + b;
						col_s <= ck;
					end
				endcase
			end
		end
	end

	assign m_tvalid = v_q[OUT];
	assign m_tdata  = {col_s, row_s};
	assign m_tuser  = err_s;
endmodule

// ----- rtl/spc_checker.sv -----
// port-level checks for the spiral index to coordinate core
module spc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	// an error result carries zero coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("error result with nonzero coordinates");

	// a free output lets the whole pipeline move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
endmodule

bind spiral_index_to_coordinate_core spc_checker u_spc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
